// ===== hw/rtl/swm_pkg.sv =====
`default_nettype none
package swm_pkg;

  localparam int SWM_WINDOW_MAX  = 64;
  localparam int SWM_SAMPLE_BITS = 16;
  localparam int CFG_LEN_W       = 7;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;

  localparam logic [CFG_LEN_W-1:0] WINDOW_LENGTH_RESET = 7'd3;

  typedef enum logic {
    REG_WINDOW_LENGTH = 1'b0,
    REG_UNUSED        = 1'b1
  } swm_reg_t;

  typedef struct packed {
    logic en;
    logic full;
    logic rm_low;
  } swm_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/swm_cell.sv =====
`default_nettype none
module swm_cell
  import swm_pkg::*;
#(
  parameter int SAMPLE_BITS = SWM_SAMPLE_BITS,
  parameter int AGE_W       = 6
) (
  input  wire                           clk,
  input  wire swm_ctrl_t                ctrl,
  input  wire logic signed [SAMPLE_BITS-1:0] x,
  input  wire logic [AGE_W-1:0]         len_m1,
  input  wire logic                     valid,
  input  wire logic signed [SAMPLE_BITS-1:0] prev_val,
  input  wire logic [AGE_W-1:0]         prev_age,
  input  wire logic                     prev_le,
  input  wire logic signed [SAMPLE_BITS-1:0] next_val,
  input  wire logic [AGE_W-1:0]         next_age,
  input  wire logic                     next_le,
  input  wire logic                     rb_in,
  output logic                          rb_out,
  output logic                          rm,
  output logic                          le,
  output logic signed [SAMPLE_BITS-1:0] val,
  output logic [AGE_W-1:0]              age
);

  logic signed [SAMPLE_BITS-1:0] val_r, val_nxt;
  logic [AGE_W-1:0]              age_r, age_nxt;
  logic                          at_or_above;

  assign val = val_r;
  assign age = age_r;

  always_comb begin
    le          = valid && (val_r <= x);
    rm          = valid && ctrl.full && (age_r == len_m1);
    rb_out      = rb_in | rm;
    at_or_above = rb_in | rm;
  end

  always_comb begin
    val_nxt = val_r;
    age_nxt = AGE_W'(age_r + 1'b1);
    if (ctrl.rm_low) begin
      if (at_or_above && next_le) begin
        val_nxt = next_val;
        age_nxt = AGE_W'(next_age + 1'b1);
      end else if (at_or_above && le) begin
        val_nxt = x;
        age_nxt = '0;
      end
    end else begin
      if (le) begin
        val_nxt = val_r;
      end else if (prev_le) begin
        val_nxt = x;
        age_nxt = '0;
      end else if (!rb_in) begin
        val_nxt = prev_val;
        age_nxt = AGE_W'(prev_age + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/swm_median.sv =====
`default_nettype none
module swm_median
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX  = SWM_WINDOW_MAX,
  parameter int SAMPLE_BITS = SWM_SAMPLE_BITS,
  parameter int IDX_W       = 6
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire logic signed [SAMPLE_BITS-1:0] vals [WINDOW_MAX],
  input  wire logic [IDX_W-1:0]          mid_lo,
  input  wire logic [IDX_W-1:0]          mid_hi,
  input  wire logic                      pend,
  output logic                           take,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [SAMPLE_BITS:0]    out_median_doubled
);

  logic                          valid_r, valid_nxt;
  logic signed [SAMPLE_BITS:0]   med_r, med_nxt;
  logic [SAMPLE_BITS-1:0]        lo_sel, hi_sel;
  logic signed [SAMPLE_BITS-1:0] lo_val, hi_val;

  always_comb begin
    lo_sel = '0;
    hi_sel = '0;
    for (int k = 0; k < WINDOW_MAX; k++) begin
      lo_sel = lo_sel | (vals[k] & {SAMPLE_BITS{mid_lo == IDX_W'(k)}});
      hi_sel = hi_sel | (vals[k] & {SAMPLE_BITS{mid_hi == IDX_W'(k)}});
    end
    lo_val = signed'(lo_sel);
    hi_val = signed'(hi_sel);
  end

  assign take = pend && (!valid_r || !out_stall);

  always_comb begin
    valid_nxt = valid_r;
    med_nxt   = med_r;
    if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
    if (take) begin
      valid_nxt = 1'b1;
      med_nxt   = (SAMPLE_BITS+1)'(lo_val) + (SAMPLE_BITS+1)'(hi_val);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    med_r <= med_nxt;
  end

  assign out_valid          = valid_r;
  assign out_median_doubled = med_r;

endmodule
`default_nettype wire

// ===== hw/rtl/sliding_window_median.sv =====
`default_nettype none
// Channel  | Ports                                        | Direction
// ---------+----------------------------------------------+----------
// input    | in_valid, in_stall, in_sample, in_start_sequence | in
// result   | out_valid, out_stall, out_median_doubled     | out
// config   | cfg_psel/penable/pwrite/paddr/pwdata/prdata/pready | APB
//
// One sample per cycle while in_stall is low: a sorted row of WINDOW_MAX cells takes out the oldest
// sample and inserts the new one in the cycle of the transfer.
// The median is taken from the row into the output register when a result is pending and that register is free.
// Reset is synchronous; window_length resets to 3 and the window is empty.
// Input stalls only while a result waits and the output register is held.
module sliding_window_median
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX  = SWM_WINDOW_MAX,
  parameter int SAMPLE_BITS = SWM_SAMPLE_BITS
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire                          in_start_sequence,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic signed [SAMPLE_BITS:0]  out_median_doubled,
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [CFG_DATA_W-1:0]        cfg_prdata,
  output logic                         cfg_pready
);

  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  logic [CFG_LEN_W-1:0] wl_r, wl_nxt;
  logic [LEN_W-1:0]     fill_r, fill_nxt;
  logic                 pend_r, pend_nxt;

  logic [LEN_W-1:0]     len;
  logic [IDX_W-1:0]     len_m1;
  logic [IDX_W-1:0]     mid_lo, mid_hi;
  logic [LEN_W-1:0]     count_eff, fill_new;
  logic                 in_acc, cfg_wr, take, emit;
  swm_ctrl_t            ctrl;

  logic signed [SAMPLE_BITS-1:0] cell_val [WINDOW_MAX];
  logic [IDX_W-1:0]              cell_age [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]         cell_le, cell_rm, cell_valid;
  logic [WINDOW_MAX:0]           cell_rb;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (swm_reg_t'(cfg_paddr[2]) == REG_WINDOW_LENGTH);

  always_comb begin
    cfg_prdata = '0;
    if (swm_reg_t'(cfg_paddr[2]) == REG_WINDOW_LENGTH) begin
      cfg_prdata = CFG_DATA_W'(wl_r);
    end
  end

  always_comb begin
    if (wl_r == '0) begin
      len = LEN_W'(1);
    end else if (32'(wl_r) > 32'(WINDOW_MAX)) begin
      len = LEN_W'(WINDOW_MAX);
    end else begin
      len = LEN_W'(wl_r);
    end
    len_m1 = IDX_W'(len - 1'b1);
    mid_hi = IDX_W'(len >> 1);
    mid_lo = len[0] ? mid_hi : IDX_W'(mid_hi - 1'b1);
  end

  assign in_stall = pend_r && !take;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    count_eff   = in_start_sequence ? '0 : fill_r;
    ctrl.en     = in_acc;
    ctrl.full   = (count_eff >= len);
    ctrl.rm_low = |(cell_rm & cell_le);
    fill_new    = ctrl.full ? count_eff : LEN_W'(count_eff + 1'b1);
    emit        = (fill_new >= len);
    for (int k = 0; k < WINDOW_MAX; k++) begin
      cell_valid[k] = (32'(count_eff) > k);
    end
  end

  assign cell_rb[0] = 1'b0;

  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] p_val, n_val;
    logic [IDX_W-1:0]              p_age, n_age;
    logic                          p_le, n_le;
    if (k == 0) begin : g_first
      assign p_val = cell_val[k];
      assign p_age = cell_age[k];
      assign p_le  = 1'b1;
    end else begin : g_mid
      assign p_val = cell_val[k-1];
      assign p_age = cell_age[k-1];
      assign p_le  = cell_le[k-1];
    end
    if (k == WINDOW_MAX - 1) begin : g_last
      assign n_val = cell_val[k];
      assign n_age = cell_age[k];
      assign n_le  = 1'b0;
    end else begin : g_inner
      assign n_val = cell_val[k+1];
      assign n_age = cell_age[k+1];
      assign n_le  = cell_le[k+1];
    end
    swm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .AGE_W       (IDX_W)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .x        (in_sample),
      .len_m1   (len_m1),
      .valid    (cell_valid[k]),
      .prev_val (p_val),
      .prev_age (p_age),
      .prev_le  (p_le),
      .next_val (n_val),
      .next_age (n_age),
      .next_le  (n_le),
      .rb_in    (cell_rb[k]),
      .rb_out   (cell_rb[k+1]),
      .rm       (cell_rm[k]),
      .le       (cell_le[k]),
      .val      (cell_val[k]),
      .age      (cell_age[k])
    );
  end

  swm_median #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS),
    .IDX_W       (IDX_W)
  ) u_median (
    .clk                (clk),
    .rst_n              (rst_n),
    .vals               (cell_val),
    .mid_lo             (mid_lo),
    .mid_hi             (mid_hi),
    .pend               (pend_r),
    .take               (take),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_median_doubled (out_median_doubled)
  );

  always_comb begin
    wl_nxt   = wl_r;
    fill_nxt = fill_r;
    pend_nxt = pend_r;
    if (take) begin
      pend_nxt = 1'b0;
    end
    if (in_acc) begin
      fill_nxt = fill_new;
      pend_nxt = emit;
    end
    if (cfg_wr) begin
      wl_nxt   = cfg_pwdata[CFG_LEN_W-1:0];
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r   <= WINDOW_LENGTH_RESET;
      fill_r <= '0;
      pend_r <= 1'b0;
    end else begin
      wl_r   <= wl_nxt;
      fill_r <= fill_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule
`default_nettype wire
